// File: rtl/hno_pkg.sv
// Shared types and constants for the heightfield neighbour occlusion block.
// No dependencies; every other file in rtl/ imports this package.
package hno_pkg;

  // Default grid side; the top level takes it as its parameter default
  localparam int unsigned MAX_SIDE_DEF = 64;

  // Datapath widths
  localparam int unsigned HEIGHT_W = 32;           // signed Q16.16 height
  localparam int unsigned ENTRY_W  = HEIGHT_W + 1; // present bit over height
  localparam int unsigned MUL_A_W  = 36;           // rise, or occlusion sum
  localparam int unsigned MUL_B_W  = 32;           // inverse horizon, or strength
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DIVD_W   = 11;           // scaled rounding numerator
  localparam int unsigned DIVS_W   = 4;            // sample count, 1..8
  localparam int unsigned QUOT_W   = 8;            // occlusion byte

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register map
  typedef enum logic [1:0] {
    CFG_GRID_SIDE   = 2'd0,
    CFG_INV_HORIZON = 2'd1,
    CFG_STRENGTH    = 2'd2
  } cfg_idx_e;

  // Register reset values
  localparam logic [6:0]  GRID_SIDE_RST   = 7'd64;
  localparam logic [31:0] INV_HORIZON_RST = 32'd65536;
  localparam logic [15:0] STRENGTH_RST    = 16'd256;

  // Neighbour offsets, row above, same row, row below
  localparam logic signed [1:0] NBR_DX [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                               2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] NBR_DZ [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                               2'sd0, 2'sd1, 2'sd1, 2'sd1};

  // Input word
  typedef struct packed {
    logic               kind;
    logic [5:0]         col_x;
    logic [5:0]         col_z;
    logic               has_surface;
    logic signed [31:0] top_height;
  } in_t;

  // Result word
  typedef struct packed {
    logic [7:0] ao_value;
    logic       ao_valid;
  } out_t;

  // Divider start request
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage

// File: rtl/heightfield_neighbour_occlusion_top.sv
// Heightfield neighbour occlusion: sequencer, config registers and result
// register. Depends on hno_pkg, hno_store, hno_mul and hno_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i) carries write and query
//   words; each gives exactly one result word on the output channel
//   (out_valid_o/out_ready_i, out_data_o). Config writes go through
//   cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; cfg_ready_o is
//   always high and registers should only change while the block is idle.
// Sequencing:
//   One word at a time. An out-of-range column goes straight to the result,
//   a write first writes the store, and a query ends early on an empty column,
//   with zero strength or when there are no samples. A full query makes one
//   memory read per in-range column (own and in-range neighbours) through the
//   single memory port, drains the multiplier, then does the scaling multiply,
//   two rounding steps and a bit-serial division by the sample count (eight
//   steps and a done flag); a fully occluded column skips the division. The
//   next word is accepted the cycle after the result is registered.
// Reset:
//   A clearing pass over all MAX_SIDE*MAX_SIDE entries (4096 by default) zeroes the
//   column store; in_ready_o stays low until it ends.
// Stalls:
//   A result waits in the output register while out_ready_i is low; the next
//   word is still accepted and computed, then held until the register frees.
module heightfield_neighbour_occlusion_top #(
  parameter int unsigned MAX_SIDE = hno_pkg::MAX_SIDE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hno_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hno_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import hno_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned CmpW  = ((SideW > 7) ? SideW : 7) + 1;
  localparam int unsigned OccW  = MUL_A_W;
  localparam int unsigned NW    = 52;   // occlusion sum times strength
  localparam int unsigned DW    = 44;   // samples scaled by 2^40
  localparam int unsigned RW    = DW + 9;
  localparam int unsigned FracW = 40;
  localparam int unsigned RndSh = FracW + 1;
  localparam int unsigned TermW = HEIGHT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_OWN, S_OWNCHK, S_NBR, S_DRAIN,
    S_SCALE, S_ROUND, S_QUOT, S_DIV, S_DONE
  } state_e;

  // Config registers
  logic [6:0]  grid_side_q;
  logic [31:0] inv_hor_q;
  logic [15:0] strength_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RST;
      inv_hor_q   <= INV_HORIZON_RST;
      strength_q  <= STRENGTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_SIDE:   grid_side_q <= cfg_data_i[6:0];
        CFG_INV_HORIZON: inv_hor_q   <= cfg_data_i;
        CFG_STRENGTH:    strength_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e            state_q, state_d;
  in_t               item_q, item_d;
  logic [2:0]        k_q, k_d;
  logic              s1_v_q, s1_v_d;
  logic              s2_v_q, s2_v_d;
  logic [DIVS_W-1:0] samples_q, samples_d;
  logic [31:0]       own_h_q, own_h_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [DW-1:0]     diff_q, diff_d;
  out_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q, out_data_d;

  // Store, multiplier and divider hookup
  logic               mem_en, mem_we;
  logic [AddrW-1:0]   mem_addr;
  logic [ENTRY_W-1:0] mem_wdata, rd_data;
  logic               store_busy;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  div_req_t           div_req;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;

  // Effective side and coordinate checks
  logic [CmpW-1:0]  gs_ext, side_c;
  logic             in_ok;
  logic [CmpW-1:0]  nx_c, nz_c;
  logic             nbr_ok;
  logic [AddrW-1:0] own_addr, nbr_addr;

  assign gs_ext = CmpW'(grid_side_q);
  assign side_c = (gs_ext > CmpW'(MAX_SIDE)) ? CmpW'(MAX_SIDE) : gs_ext;
  assign in_ok  = (CmpW'(in_data_i.col_x) < side_c) && (CmpW'(in_data_i.col_z) < side_c);

  // An offset of -1 at coordinate 0 wraps to all ones, which is never in range
  assign nx_c = CmpW'(item_q.col_x) + {{(CmpW-2){NBR_DX[k_q][1]}}, NBR_DX[k_q]};
  assign nz_c = CmpW'(item_q.col_z) + {{(CmpW-2){NBR_DZ[k_q][1]}}, NBR_DZ[k_q]};
  assign nbr_ok = (nx_c < side_c) && (nz_c < side_c);

  assign own_addr = AddrW'(32'(item_q.col_z) * 32'(MAX_SIDE) + 32'(item_q.col_x));
  assign nbr_addr = AddrW'(32'(nz_c) * 32'(MAX_SIDE) + 32'(nx_c));

  // Neighbour stage: rise against own height, gated to positive present rises
  logic signed [TermW-1:0] rise;
  logic                    rise_pos;
  logic [TermW-1:0]        term_c;

  assign rise = $signed({rd_data[HEIGHT_W-1], rd_data[HEIGHT_W-1:0]})
              - $signed({own_h_q[HEIGHT_W-1], own_h_q});
  assign rise_pos = !rise[TermW-1] && (rise != '0);

  // Clamp each term to 1.0 in Q1.32
  assign term_c = (mul_p > (MUL_P_W'(1) << HEIGHT_W)) ? (TermW'(1) << HEIGHT_W)
                                                      : mul_p[TermW-1:0];

  // Rounding: byte = (510*(D-N) + D) / (2*D), D = samples*2^40
  logic [DW-1:0] d_c;
  logic [NW-1:0] n_c;
  logic [RW-1:0] r_c;

  assign d_c = {samples_q, FracW'(0)};
  assign n_c = mul_p[NW-1:0];
  assign r_c = (RW'(diff_q) << 9) - (RW'(diff_q) << 1) + RW'(d_c);

  // Multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = inv_hor_q;
    if (state_q == S_SCALE) begin
      mul_a = occ_q;
      mul_b = MUL_B_W'(strength_q);
    end else if (s1_v_q && rd_data[ENTRY_W-1] && rise_pos) begin
      mul_a = MUL_A_W'(rise[HEIGHT_W-1:0]);
    end
  end

  // Memory requests
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = own_addr;
    mem_wdata = {item_q.has_surface, item_q.top_height};
    case (state_q)
      S_WRITE: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end
      S_OWN: begin
        mem_en = 1'b1;
      end
      S_NBR: begin
        mem_en   = nbr_ok;
        mem_addr = nbr_addr;
      end
      default: ;
    endcase
  end

  assign div_req.start    = (state_q == S_QUOT);
  assign div_req.dividend = r_c[RndSh+DIVD_W-1:RndSh];
  assign div_req.divisor  = samples_q;

  assign in_ready_o = (state_q == S_IDLE) && !store_busy;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    k_d         = k_q;
    s1_v_d      = (state_q == S_NBR) && nbr_ok;
    s2_v_d      = s1_v_q;
    samples_d   = samples_q;
    own_h_d     = own_h_q;
    occ_d       = occ_q;
    diff_d      = diff_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    // Accumulate clamped terms leaving the multiplier
    if (s2_v_q) begin
      occ_d = occ_q + OccW'(term_c);
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d    = in_data_i;
          res_d     = '0;
          occ_d     = '0;
          samples_d = '0;
          k_d       = '0;
          if (!in_ok) begin
            state_d = S_DONE;
          end else if (in_data_i.kind == KIND_WRITE) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_OWN;
          end
        end
      end
      S_WRITE: state_d = S_DONE;
      S_OWN:   state_d = S_OWNCHK;
      S_OWNCHK: begin
        own_h_d = rd_data[HEIGHT_W-1:0];
        if (!rd_data[ENTRY_W-1] || (strength_q == '0)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_NBR;
        end
      end
      S_NBR: begin
        samples_d = samples_q + DIVS_W'(nbr_ok);
        k_d       = k_q + 3'd1;
        if (k_q == 3'd7) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = (samples_q == '0) ? S_DONE : S_SCALE;
        end
      end
      S_SCALE: state_d = S_ROUND;
      S_ROUND: begin
        res_d.ao_valid = 1'b1;
        if (NW'(d_c) <= n_c) begin
          state_d = S_DONE;
        end else begin
          diff_d  = DW'(NW'(d_c) - n_c);
          state_d = S_QUOT;
        end
      end
      S_QUOT: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          res_d.ao_value = div_quot;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      k_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      samples_q   <= '0;
      own_h_q     <= '0;
      occ_q       <= '0;
      diff_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      k_q         <= k_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      samples_q   <= samples_d;
      own_h_q     <= own_h_d;
      occ_q       <= occ_d;
      diff_q      <= diff_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  hno_store #(
    .MAX_SIDE(MAX_SIDE)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mem_en_i   (mem_en),
    .mem_we_i   (mem_we),
    .mem_addr_i (mem_addr),
    .mem_wdata_i(mem_wdata),
    .rd_data_o  (rd_data),
    .busy_o     (store_busy)
  );

  hno_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  hno_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

endmodule

// File: rtl/hno_store.sv
// Column store: one single-port memory of present bit plus height per column,
// with a clearing pass after reset. Depends on hno_pkg.
module hno_store #(
  parameter int unsigned MAX_SIDE = hno_pkg::MAX_SIDE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 mem_en_i,
  input  logic                                 mem_we_i,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] mem_addr_i,
  input  logic [hno_pkg::ENTRY_W-1:0]          mem_wdata_i,
  output logic [hno_pkg::ENTRY_W-1:0]          rd_data_o,
  output logic                                 busy_o
);
  import hno_pkg::*;

  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [ENTRY_W-1:0] mem_q [Depth];
  logic [ENTRY_W-1:0] rd_q;
  logic               busy_q, busy_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;

  // Clearing sweep, one entry a cycle
  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Memory array, registered read
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (mem_en_i && mem_we_i) begin
      mem_q[mem_addr_i] <= mem_wdata_i;
    end
    if (mem_en_i && !mem_we_i) begin
      rd_q <= mem_q[mem_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

// File: rtl/hno_mul.sv
// Shared registered multiplier: rise by inverse horizon per neighbour,
// then occlusion sum by strength. Depends on hno_pkg.
module hno_mul (
  input  logic                        clk_i,
  input  logic [hno_pkg::MUL_A_W-1:0] a_i,
  input  logic [hno_pkg::MUL_B_W-1:0] b_i,
  output logic [hno_pkg::MUL_P_W-1:0] p_o
);
  import hno_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  // One product a cycle, registered so the result shows the cycle after
  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/hno_div.sv
// Restoring divider, one quotient bit a cycle, for the final rounding step.
// Dividend over divisor must stay below 2^QUOT_W. Depends on hno_pkg.
module hno_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hno_pkg::div_req_t          req_i,
  output logic                       done_o,
  output logic [hno_pkg::QUOT_W-1:0] quot_o
);
  import hno_pkg::*;

  localparam int unsigned CntW = $clog2(QUOT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [QUOT_W-1:0] dvd_q, dvd_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DIVS_W-1:0] trial;
  logic              fits;

  // Remainder stays below the divisor, so its top bit is always clear
  assign trial = {rem_q[DIVS_W-2:0], dvd_q[QUOT_W-1]};
  assign fits  = (trial >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DIVS_W'(req_i.dividend[DIVD_W-1:QUOT_W]);
      dvs_d  = req_i.divisor;
      dvd_d  = req_i.dividend[QUOT_W-1:0];
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? (trial - dvs_q) : trial;
      dvd_d  = {dvd_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dvd_q  <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      dvd_q  <= dvd_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/hno_checker.sv
// Port-level checks for the occlusion block, bound to the top level.
// Depends on hno_pkg and heightfield_neighbour_occlusion_top.
module hno_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input hno_pkg::out_t out_data_o
);
  import hno_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Invalid results carry a zero byte
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ao_valid |-> out_data_o.ao_value == 8'd0)
    else $error("invalid result with non-zero byte");

  // One word at a time: busy straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // No result can appear the cycle after acceptance
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind heightfield_neighbour_occlusion_top hno_checker u_hno_checker (.*);
